>>> rtl/sbldc_pkg.sv
package sbldc_pkg;

	localparam int PERIOD_W = 16;
	localparam int PCT_W = 7;
	localparam int COUNT_W = 8;
	localparam int PROD_W = PERIOD_W + PCT_W;
	localparam int RECIP_W = 24;
	localparam int SCALED_W = PROD_W + RECIP_W;
	localparam int RECIP_SHIFT = 30;
	localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
	localparam int QUOT_W = SCALED_W - RECIP_SHIFT;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_EVENT = 2'd2;

	localparam logic [2:0] REG_PWM_PERIOD = 3'd0;
	localparam logic [2:0] REG_ALIGN_DUTY = 3'd1;
	localparam logic [2:0] REG_START_DUTY = 3'd2;
	localparam logic [2:0] REG_LOCK_COUNT = 3'd3;
	localparam logic [2:0] REG_MAX_FORCED = 3'd4;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_RUN = 2'd2;
	localparam logic [1:0] MODE_FAIL = 2'd3;

	localparam logic [2:0] NO_STEP = 3'd7;
	localparam logic [2:0] ALIGN_STEP = 3'd5;
	localparam logic [2:0] LAST_STEP = 3'd5;
	localparam logic [2:0] NUM_STEPS = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_RUN   = 4'b0100,
		ST_FAIL  = 4'b1000
	} run_state_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] pwm_period;
		logic [PCT_W-1:0]    align_duty_pct;
		logic [PCT_W-1:0]    start_duty_pct;
		logic [COUNT_W-1:0]  lock_count;
		logic [COUNT_W-1:0]  max_forced_steps;
	} sbldc_cfg_t;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [2:0]          pattern;
		logic                same;
		logic [2:0]          next_step;
		logic [PERIOD_W-1:0] duty;
	} sbldc_item_t;

	function automatic logic [2:0] expect_pattern(input logic [2:0] s);
		logic [2:0] r;
		unique case (s)
			3'd0: r = 3'h4;
			3'd1: r = 3'h6;
			3'd2: r = 3'h2;
			3'd3: r = 3'h3;
			3'd4: r = 3'h1;
			3'd5: r = 3'h5;
			default: r = 3'h0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] pattern_to_step(input logic [2:0] p);
		logic [2:0] r;
		unique case (p)
			3'd1: r = 3'd5;
			3'd2: r = 3'd3;
			3'd3: r = 3'd4;
			3'd4: r = 3'd1;
			3'd5: r = 3'd0;
			3'd6: r = 3'd2;
			default: r = NO_STEP;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] enable_low_of(input logic [2:0] s);
		logic [7:0] r;
		unique case (s)
			3'd2, 3'd3: r = 8'h10;
			3'd4, 3'd5: r = 8'h01;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] enable_high_of(input logic [2:0] s);
		logic [7:0] r;
		unique case (s)
			3'd0, 3'd1: r = 8'h01;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] low_side_of(input logic [2:0] s);
		logic [2:0] r;
		unique case (s)
			3'd0, 3'd5: r = 3'h2;
			3'd1, 3'd2: r = 3'h4;
			default: r = 3'h1;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] channel_of(input logic [2:0] s);
		logic [1:0] r;
		unique case (s)
			3'd2, 3'd3: r = 2'd2;
			3'd4, 3'd5: r = 2'd1;
			default: r = 2'd3;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] mode_code(input run_state_t m);
		logic [1:0] r;
		unique case (m)
			ST_START: r = MODE_START;
			ST_RUN: r = MODE_RUN;
			ST_FAIL: r = MODE_FAIL;
			default: r = MODE_IDLE;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/sensorless_bldc_commutator.sv
// Six-step sensorless commutator. Each beat on the input channel (start, forced tick or
// back-EMF event) gives exactly one result beat. The block takes one beat per clock when
// the queue is not full: a two-stage front computes the duty as period times percent over
// 100 with two registered multiplies, a two-entry queue decouples it from the back, which
// updates the commutation state and loads the output register together on each pop. An
// accepted beat passes stage 1, stage 2, the queue and the output register in that order.
// Configuration writes take effect at once and must be made while no beats are in flight.
module sensorless_bldc_commutator import sbldc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [2:0]  first_sample,
	input  logic [2:0]  second_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  mode,
	output logic [2:0]  step,
	output logic [15:0] compare_value,
	output logic [1:0]  compare_channel,
	output logic [2:0]  low_side_on,
	output logic [7:0]  enable_word_low,
	output logic [7:0]  enable_word_high,
	output logic        drive_enabled,
	output logic        led_toggle,
	output logic        fault
);

	sbldc_cfg_t  cfg_q;
	sbldc_item_t push_item;
	sbldc_item_t pop_item;
	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_period <= 16'd1000;
			cfg_q.align_duty_pct <= 7'd15;
			cfg_q.start_duty_pct <= 7'd15;
			cfg_q.lock_count <= 8'd30;
			cfg_q.max_forced_steps <= 8'd200;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PWM_PERIOD: cfg_q.pwm_period <= cfg_data;
				REG_ALIGN_DUTY: cfg_q.align_duty_pct <= cfg_data[PCT_W-1:0];
				REG_START_DUTY: cfg_q.start_duty_pct <= cfg_data[PCT_W-1:0];
				REG_LOCK_COUNT: cfg_q.lock_count <= cfg_data[COUNT_W-1:0];
				REG_MAX_FORCED: cfg_q.max_forced_steps <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sbldc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.first_sample  (first_sample),
		.second_sample (second_sample),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	sbldc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_item  (pop_item)
	);

	sbldc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_not_empty      (q_not_empty),
		.q_item           (pop_item),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.mode             (mode),
		.step             (step),
		.compare_value    (compare_value),
		.compare_channel  (compare_channel),
		.low_side_on      (low_side_on),
		.enable_word_low  (enable_word_low),
		.enable_word_high (enable_word_high),
		.drive_enabled    (drive_enabled),
		.led_toggle       (led_toggle),
		.fault            (fault)
	);

endmodule

>>> rtl/sbldc_front.sv
module sbldc_front import sbldc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sbldc_cfg_t  cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [2:0]  first_sample,
	input  logic [2:0]  second_sample,
	input  logic        q_full,
	output logic        q_push,
	output sbldc_item_t q_item
);

	logic                v_s1;
	logic                v_s2;
	logic [1:0]          cmd_s1;
	logic [1:0]          cmd_s2;
	logic [2:0]          pat_s1;
	logic [2:0]          pat_s2;
	logic                same_s1;
	logic                same_s2;
	logic [PROD_W-1:0]   prod_s1;
	logic [SCALED_W-1:0] scaled_s2;
	logic [PCT_W-1:0]    pct;
	logic [QUOT_W-1:0]   quot;
	logic                adv;

	assign adv = !v_s2 || !q_full;
	assign in_ready = adv;
	assign pct = (cmd == CMD_START) ? cfg.align_duty_pct : cfg.start_duty_pct;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd;
			pat_s1 <= first_sample;
			same_s1 <= (first_sample == second_sample);
			prod_s1 <= PROD_W'(cfg.pwm_period) * PROD_W'(pct);
			cmd_s2 <= cmd_s1;
			pat_s2 <= pat_s1;
			same_s2 <= same_s1;
			scaled_s2 <= SCALED_W'(prod_s1) * SCALED_W'(RECIP_100);
		end
	end

	assign quot = scaled_s2[SCALED_W-1:RECIP_SHIFT];
	assign q_push = v_s2 && !q_full;

	always_comb begin
		q_item.cmd = cmd_s2;
		q_item.pattern = pat_s2;
		q_item.same = same_s2;
		q_item.next_step = pattern_to_step(pat_s2);
		q_item.duty = quot[QUOT_W-1:PERIOD_W] != '0 ? '1 : quot[PERIOD_W-1:0];
	end

endmodule

>>> rtl/sbldc_fifo.sv
module sbldc_fifo import sbldc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  sbldc_item_t push_item,
	output logic        full,
	input  logic        pop,
	output logic        not_empty,
	output sbldc_item_t pop_item
);

	sbldc_item_t entries_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full = count_q[1];
	assign not_empty = count_q != 2'd0;
	assign pop_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty)) else $error("queue read while empty");

endmodule

>>> rtl/sbldc_back.sv
module sbldc_back import sbldc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sbldc_cfg_t  cfg,
	input  logic        q_not_empty,
	input  sbldc_item_t q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  mode,
	output logic [2:0]  step,
	output logic [15:0] compare_value,
	output logic [1:0]  compare_channel,
	output logic [2:0]  low_side_on,
	output logic [7:0]  enable_word_low,
	output logic [7:0]  enable_word_high,
	output logic        drive_enabled,
	output logic        led_toggle,
	output logic        fault
);

	run_state_t          run_q;
	run_state_t          run_d;
	logic [2:0]          step_q;
	logic [2:0]          step_d;
	logic [COUNT_W-1:0]  good_q;
	logic [COUNT_W-1:0]  good_d;
	logic [COUNT_W-1:0]  forced_q;
	logic [COUNT_W-1:0]  forced_d;
	logic [PERIOD_W-1:0] cmp_q;
	logic [PERIOD_W-1:0] cmp_d;
	logic                drive_q;
	logic                drive_d;
	logic                led_d;
	logic                fault_d;
	logic [2:0]          st;
	logic                out_valid_q;
	logic [1:0]          mode_q;
	logic [2:0]          step_out_q;
	logic [15:0]         cmp_out_q;
	logic [1:0]          channel_q;
	logic [2:0]          low_side_q;
	logic [7:0]          en_low_q;
	logic [7:0]          en_high_q;
	logic                drive_out_q;
	logic                led_q;
	logic                fault_q;

	assign q_pop = q_not_empty && (!out_valid_q || out_ready);

	always_comb begin
		run_d = run_q;
		step_d = step_q;
		good_d = good_q;
		forced_d = forced_q;
		cmp_d = cmp_q;
		drive_d = drive_q;
		led_d = 1'b0;
		fault_d = 1'b0;
		unique case (q_item.cmd)
			CMD_START: begin
				run_d = ST_START;
				good_d = '0;
				forced_d = '0;
				step_d = ALIGN_STEP;
				cmp_d = q_item.duty;
				drive_d = 1'b1;
			end
			CMD_TICK: begin
				if (run_q == ST_START) begin
					step_d = (step_q >= LAST_STEP) ? 3'd0 : step_q + 3'd1;
					cmp_d = q_item.duty;
					drive_d = 1'b1;
					if (forced_q != '1) begin
						forced_d = forced_q + COUNT_W'(1);
					end
					if (forced_d >= cfg.max_forced_steps) begin
						drive_d = 1'b0;
						run_d = ST_FAIL;
					end
				end
			end
			CMD_EVENT: begin
				if ((run_q == ST_START || run_q == ST_RUN) && q_item.same) begin
					if (run_q == ST_START) begin
						if (step_q < NUM_STEPS && q_item.pattern == expect_pattern(step_q)) begin
							if (good_q != '1) begin
								good_d = good_q + COUNT_W'(1);
							end
							led_d = 1'b1;
						end else begin
							good_d = '0;
						end
						if (good_d >= cfg.lock_count) begin
							run_d = ST_RUN;
						end
					end
					if (run_d == ST_RUN) begin
						if (q_item.next_step == NO_STEP) begin
							drive_d = 1'b0;
							fault_d = 1'b1;
						end else begin
							step_d = q_item.next_step;
							cmp_d = q_item.duty;
							drive_d = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
		if (run_d == ST_FAIL) begin
			fault_d = 1'b1;
		end
		st = (step_d < NUM_STEPS) ? step_d : 3'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= ST_IDLE;
			step_q <= '0;
			good_q <= '0;
			forced_q <= '0;
			cmp_q <= '0;
			drive_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				run_q <= run_d;
				step_q <= step_d;
				good_q <= good_d;
				forced_q <= forced_d;
				cmp_q <= cmp_d;
				drive_q <= drive_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			mode_q <= mode_code(run_d);
			step_out_q <= step_d;
			cmp_out_q <= cmp_d;
			channel_q <= channel_of(st);
			low_side_q <= drive_d ? low_side_of(st) : 3'd0;
			en_low_q <= drive_d ? enable_low_of(st) : 8'd0;
			en_high_q <= drive_d ? enable_high_of(st) : 8'd0;
			drive_out_q <= drive_d;
			led_q <= led_d;
			fault_q <= fault_d;
		end
	end

	assign out_valid = out_valid_q;
	assign mode = mode_q;
	assign step = step_out_q;
	assign compare_value = cmp_out_q;
	assign compare_channel = channel_q;
	assign low_side_on = low_side_q;
	assign enable_word_low = en_low_q;
	assign enable_word_high = en_high_q;
	assign drive_enabled = drive_out_q;
	assign led_toggle = led_q;
	assign fault = fault_q;

	a_fail_drive_off: assert property (@(posedge clk) disable iff (!arst_n)
		run_q == ST_FAIL |-> !drive_q) else $error("drive on while failed");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < NUM_STEPS) else $error("step out of range");
	a_tick_counts: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_item.cmd == CMD_TICK && run_q == ST_START |=> forced_q != '0)
		else $error("forced tick not counted");

endmodule

>>> tb/sv/commutation_checker.sv
module commutation_checker import sbldc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [2:0]  first_sample,
	input  logic [2:0]  second_sample,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  mode,
	input  logic [2:0]  step,
	input  logic [15:0] compare_value,
	input  logic [1:0]  compare_channel,
	input  logic [2:0]  low_side_on,
	input  logic [7:0]  enable_word_low,
	input  logic [7:0]  enable_word_high,
	input  logic        drive_enabled,
	input  logic        led_toggle,
	input  logic        fault,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// Per-step and per-pattern tables, entry 0 in the low bits.
	localparam logic [17:0] CROSSING_PATTERNS = {3'h5, 3'h1, 3'h3, 3'h2, 3'h6, 3'h4};
	localparam logic [23:0] STEP_OF_PATTERN =
		{NO_STEP, 3'd2, 3'd0, 3'd1, 3'd4, 3'd3, 3'd5, NO_STEP};
	localparam logic [47:0] ENABLE_LOW_BY_STEP =
		{8'h01, 8'h01, 8'h10, 8'h10, 8'h00, 8'h00};
	localparam logic [47:0] ENABLE_HIGH_BY_STEP =
		{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01};
	localparam logic [17:0] LOW_SIDE_BY_STEP = {3'h2, 3'h1, 3'h1, 3'h4, 3'h4, 3'h2};
	localparam logic [11:0] CHANNEL_BY_STEP = {2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3};

	typedef struct packed {
		logic [1:0]  mode;
		logic [2:0]  step;
		logic [15:0] compare;
		logic [1:0]  channel;
		logic [2:0]  low_side;
		logic [7:0]  en_low;
		logic [7:0]  en_high;
		logic        drive;
		logic        led;
		logic        fault;
	} drive_status_t;

	logic [15:0] period;
	logic [6:0]  align_pct;
	logic [6:0]  start_pct;
	logic [7:0]  lock_need;
	logic [7:0]  forced_limit;

	logic [1:0]  motor_mode;
	logic [2:0]  cur_step;
	logic [7:0]  crossings;
	logic [7:0]  forced_done;
	logic [15:0] compare_reg;
	logic        bridge_on;

	drive_status_t expected_status[$];

	function automatic logic [15:0] duty_for(input logic [6:0] pct);
		logic [31:0] prod;
		prod = 32'(period);
		prod = prod * 32'(pct);
		prod = prod / 32'd100;
		return (prod > 32'hFFFF) ? 16'hFFFF : prod[15:0];
	endfunction

	function automatic drive_status_t advance(input logic [1:0] c, input logic [2:0] a,
			input logic [2:0] b);
		drive_status_t r;
		logic [2:0] target;
		logic led;
		logic flt;
		led = 1'b0;
		flt = 1'b0;
		case (c)
			CMD_START: begin
				motor_mode = MODE_START;
				crossings = '0;
				forced_done = '0;
				cur_step = ALIGN_STEP;
				compare_reg = duty_for(align_pct);
				bridge_on = 1'b1;
			end
			CMD_TICK: begin
				if (motor_mode == MODE_START) begin
					cur_step = (cur_step >= LAST_STEP) ? 3'd0 : cur_step + 3'd1;
					compare_reg = duty_for(start_pct);
					bridge_on = 1'b1;
					if (forced_done != 8'hFF)
						forced_done++;
					if (forced_done >= forced_limit) begin
						bridge_on = 1'b0;
						motor_mode = MODE_FAIL;
					end
				end
			end
			CMD_EVENT: begin
				if ((motor_mode == MODE_START || motor_mode == MODE_RUN) && a == b) begin
					if (motor_mode == MODE_START) begin
						if (a == CROSSING_PATTERNS[cur_step*3 +: 3]) begin
							if (crossings != 8'hFF)
								crossings++;
							led = 1'b1;
						end else begin
							crossings = '0;
						end
						if (crossings >= lock_need)
							motor_mode = MODE_RUN;
					end
					// The event that reaches lock also commutates by its own pattern.
					if (motor_mode == MODE_RUN) begin
						target = STEP_OF_PATTERN[a*3 +: 3];
						if (target == NO_STEP) begin
							bridge_on = 1'b0;
							flt = 1'b1;
						end else begin
							cur_step = target;
							compare_reg = duty_for(start_pct);
							bridge_on = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		if (motor_mode == MODE_FAIL)
			flt = 1'b1;
		r.mode = motor_mode;
		r.step = cur_step;
		r.compare = compare_reg;
		r.channel = CHANNEL_BY_STEP[cur_step*2 +: 2];
		r.low_side = bridge_on ? LOW_SIDE_BY_STEP[cur_step*3 +: 3] : 3'd0;
		r.en_low = bridge_on ? ENABLE_LOW_BY_STEP[cur_step*8 +: 8] : 8'd0;
		r.en_high = bridge_on ? ENABLE_HIGH_BY_STEP[cur_step*8 +: 8] : 8'd0;
		r.drive = bridge_on;
		r.led = led;
		r.fault = flt;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_status_t want;
		if (!arst_n) begin
			period = 16'd1000;
			align_pct = 7'd15;
			start_pct = 7'd15;
			lock_need = 8'd30;
			forced_limit = 8'd200;
			motor_mode = MODE_IDLE;
			cur_step = '0;
			crossings = '0;
			forced_done = '0;
			compare_reg = '0;
			bridge_on = 1'b0;
			expected_status.delete();
			outstanding = 0;
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PWM_PERIOD: period = cfg_data;
					REG_ALIGN_DUTY: align_pct = cfg_data[6:0];
					REG_START_DUTY: start_pct = cfg_data[6:0];
					REG_LOCK_COUNT: lock_need = cfg_data[7:0];
					REG_MAX_FORCED: forced_limit = cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					$error("result beat arrived with no expected status pending");
					mismatches++;
				end else begin
					want = expected_status.pop_front();
					check_field("mode", 16'(want.mode), 16'(mode));
					check_field("step", 16'(want.step), 16'(step));
					check_field("compare_value", want.compare, compare_value);
					check_field("compare_channel", 16'(want.channel),
						16'(compare_channel));
					check_field("low_side_on", 16'(want.low_side), 16'(low_side_on));
					check_field("enable_word_low", 16'(want.en_low),
						16'(enable_word_low));
					check_field("enable_word_high", 16'(want.en_high),
						16'(enable_word_high));
					check_field("drive_enabled", 16'(want.drive), 16'(drive_enabled));
					check_field("led_toggle", 16'(want.led), 16'(led_toggle));
					check_field("fault", 16'(want.fault), 16'(fault));
				end
			end
			if (in_valid && in_ready)
				expected_status.push_back(advance(cmd, first_sample, second_sample));
			outstanding = expected_status.size();
		end
	end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
	import sbldc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [17:0] ZC_PATTERNS = {3'h5, 3'h1, 3'h3, 3'h2, 3'h6, 3'h4};
	localparam int TOTAL_BEATS = 750;
	localparam int CALM_FROM = 640;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [2:0]  first_sample;
	logic [2:0]  second_sample;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  mode;
	logic [2:0]  step;
	logic [15:0] compare_value;
	logic [1:0]  compare_channel;
	logic [2:0]  low_side_on;
	logic [7:0]  enable_word_low;
	logic [7:0]  enable_word_high;
	logic        drive_enabled;
	logic        led_toggle;
	logic        fault;
	int          mismatches;
	int          outstanding;

	int          beats_sent;
	int          gap_pct;
	int          stall_pct;
	bit          calm;
	bit          hold_due;
	logic [2:0]  drv_step;

	sensorless_bldc_commutator dut (.*);
	commutation_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off so the block backs up.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_due && !hold_done) begin
				out_ready <= 1'b0;
				repeat (120) @(posedge clk);
				hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 10)) @(posedge clk);
		end
	end

	task automatic send_item(input logic [1:0] c, input logic [2:0] a, input logic [2:0] b);
		if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		first_sample <= a;
		second_sample <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
		if (beats_sent >= CALM_FROM)
			calm = 1'b1;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [6:0] pick_pct;
		case ($urandom_range(0, 4))
			0: return 7'd0;
			1: return 7'd100;
			2: return 7'd127;
			default: return 7'($urandom_range(0, 100));
		endcase
	endfunction

	task automatic pick_config;
		logic [15:0] per;
		logic [7:0] lock;
		logic [7:0] lim;
		case ($urandom_range(0, 3))
			0: per = 16'd1;
			1: per = 16'hFFFF;
			default: per = 16'($urandom_range(1, 65535));
		endcase
		case ($urandom_range(0, 5))
			0: lock = 8'd0;
			1: lock = 8'd255;
			2: lock = 8'd1;
			default: lock = 8'($urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 5))
			0: lim = 8'd0;
			1: lim = 8'd1;
			2: lim = 8'd255;
			default: lim = 8'($urandom_range(20, 120));
		endcase
		if ($urandom_range(0, 4) != 0) write_reg(REG_PWM_PERIOD, per);
		if ($urandom_range(0, 4) != 0) write_reg(REG_ALIGN_DUTY, {9'd0, pick_pct()});
		if ($urandom_range(0, 4) != 0) write_reg(REG_START_DUTY, {9'd0, pick_pct()});
		if ($urandom_range(0, 4) != 0) write_reg(REG_LOCK_COUNT, {8'd0, lock});
		if ($urandom_range(0, 4) != 0) write_reg(REG_MAX_FORCED, {8'd0, lim});
	endtask

	// Start, then forced ticks interleaved with mostly correct crossings.
	task automatic spin_up;
		int n;
		logic [2:0] a;
		logic [2:0] d;
		send_item(CMD_START, 3'($urandom), 3'($urandom));
		drv_step = ALIGN_STEP;
		n = $urandom_range(2, 24);
		repeat (n) begin
			a = 3'($urandom);
			d = 3'($urandom_range(1, 7));
			case ($urandom_range(0, 9))
				8: send_item(CMD_EVENT, a, a);
				9: send_item(CMD_EVENT, a, a ^ d);
				default: send_item(CMD_EVENT, ZC_PATTERNS[drv_step*3 +: 3],
					ZC_PATTERNS[drv_step*3 +: 3]);
			endcase
			if ($urandom_range(0, 9) < 7) begin
				send_item(CMD_TICK, 3'($urandom), 3'($urandom));
				drv_step = (drv_step == LAST_STEP) ? 3'd0 : drv_step + 3'd1;
			end
		end
	endtask

	task automatic run_closed_loop;
		int n;
		logic [2:0] a;
		logic [2:0] d;
		n = $urandom_range(2, 20);
		repeat (n) begin
			a = 3'($urandom_range(1, 6));
			d = 3'($urandom_range(1, 7));
			case ($urandom_range(0, 9))
				7: begin
					a = $urandom_range(0, 1) ? 3'd7 : 3'd0;
					send_item(CMD_EVENT, a, a);
				end
				8: send_item(CMD_EVENT, a, a ^ d);
				9: send_item($urandom_range(0, 1) ? CMD_TICK : CMD_UNUSED,
					3'($urandom), 3'($urandom));
				default: send_item(CMD_EVENT, a, a);
			endcase
		end
	endtask

	task automatic chatter;
		repeat ($urandom_range(1, 10))
			send_item(2'($urandom_range(0, 3)), 3'($urandom), 3'($urandom));
	endtask

	initial begin
		int target;
		int phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = '0;
		first_sample = '0;
		second_sample = '0;
		beats_sent = 0;
		gap_pct = 25;
		stall_pct = 25;
		calm = 1'b0;
		hold_due = 1'b0;
		drv_step = ALIGN_STEP;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: commands while idle, alignment, debounce, match and mismatch.
		send_item(CMD_UNUSED, 3'd7, 3'd0);
		send_item(CMD_TICK, 3'd0, 3'd0);
		send_item(CMD_EVENT, 3'd5, 3'd5);
		send_item(CMD_START, 3'd0, 3'd0);
		send_item(CMD_EVENT, 3'd5, 3'd3);
		send_item(CMD_EVENT, 3'd5, 3'd5);
		send_item(CMD_EVENT, 3'd0, 3'd0);
		send_item(CMD_TICK, 3'd7, 3'd7);
		send_item(CMD_EVENT, 3'd4, 3'd4);
		send_item(CMD_TICK, 3'd0, 3'd0);
		send_item(CMD_UNUSED, 3'd2, 3'd2);
		send_item(CMD_EVENT, 3'd7, 3'd7);
		drain();

		// Saturated duty, lock on the first event, failure on the first tick.
		write_reg(REG_PWM_PERIOD, 16'hFFFF);
		write_reg(REG_ALIGN_DUTY, 16'd127);
		write_reg(REG_START_DUTY, 16'd100);
		write_reg(REG_LOCK_COUNT, 16'd0);
		write_reg(REG_MAX_FORCED, 16'd0);
		send_item(CMD_START, 3'd0, 3'd0);
		send_item(CMD_EVENT, 3'd0, 3'd0);
		send_item(CMD_EVENT, 3'd5, 3'd5);
		send_item(CMD_EVENT, 3'd7, 3'd7);
		send_item(CMD_EVENT, 3'd1, 3'd1);
		send_item(CMD_START, 3'd0, 3'd0);
		send_item(CMD_TICK, 3'd0, 3'd0);
		send_item(CMD_TICK, 3'd0, 3'd0);
		send_item(CMD_EVENT, 3'd2, 3'd2);
		send_item(CMD_UNUSED, 3'd0, 3'd0);
		send_item(CMD_START, 3'd0, 3'd0);

		phase = 0;
		while (beats_sent < TOTAL_BEATS) begin
			drain();
			pick_config();
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 20;
				default: gap_pct = 50;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 20;
				default: stall_pct = 50;
			endcase
			if (phase == 0)
				hold_due = 1'b1;
			target = beats_sent + $urandom_range(60, 100);
			while (beats_sent < target && beats_sent < TOTAL_BEATS) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: begin
						spin_up();
						run_closed_loop();
					end
					default: chatter();
				endcase
			end
			phase++;
		end
		drain();

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
